### rtl/bndf_pkg.sv
// Shared constants, types and functions for the Beckmann density pipeline.
package bndf_pkg;

   localparam int EXP_TABLE_DEPTH = 64;
   localparam int EXP_IDX_W = $clog2(EXP_TABLE_DEPTH + 1);
   localparam int EXP_P_W = 24 + EXP_IDX_W;

   localparam logic [63:0] LN2_Q60 = 64'h0B17_217F_7D1C_F79B;
   localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
   localparam logic [31:0] PI_Q30 = 32'd3373259426;
   localparam logic [31:0] T_CAP_Q24 = 32'h8000_0000;
   localparam logic [48:0] VAL_LIMIT = 49'h1_0000_0000_0000;
   localparam logic [31:0] MASK32 = 32'hFFFF_FFFF;

   localparam int DEN_STAGES = 9;
   localparam int DIVA_STEPS = 57;
   localparam int DIVB_STEPS = 31;
   localparam int DIVC_STEPS = 33;
   localparam int PIPE_DEPTH = DEN_STAGES + DIVA_STEPS + 1 + DIVB_STEPS + 4 + DIVC_STEPS + 2;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_GRAZE      = 2'd1,
      ST_ZERO_ROUGH = 2'd2,
      ST_SAT        = 2'd3
   } status_type;

   typedef logic [30:0] exp_rom_type [0:EXP_TABLE_DEPTH];

   // 2^30 * 2^(-i/depth) by a 24-term series
   function automatic exp_rom_type build_exp_rom();
      exp_rom_type rom;
      logic [63:0] y30;
      logic [63:0] pos;
      logic [63:0] neg;
      logic [63:0] term;
      for (int i = 0; i <= EXP_TABLE_DEPTH; i++) begin
         y30 = ((LN2_Q60 / EXP_TABLE_DEPTH) * 64'(i)
                + ((LN2_Q60 % EXP_TABLE_DEPTH) * 64'(i)) / EXP_TABLE_DEPTH) >> 30;
         pos = 64'd1 << 30;
         neg = 64'd0;
         term = 64'd1 << 30;
         for (int k = 1; k <= 24; k++) begin
            term = ((term * y30) >> 30) / 64'(k);
            if (k % 2 == 1) begin
               neg = neg + term;
            end else begin
               pos = pos + term;
            end
         end
         rom[i] = 31'(pos - neg);
      end
      return rom;
   endfunction

   localparam exp_rom_type EXP_ROM = build_exp_rom();

   function automatic logic [5:0] lead_pos64(input logic [63:0] x);
      logic [5:0] p;
      p = 6'd0;
      for (int i = 0; i < 64; i++) begin
         if (x[i]) begin
            p = 6'(i);
         end
      end
      return p;
   endfunction

   // right shift that brings x below 2^32, into [2^31, 2^32) when x >= 2^31
   function automatic logic [5:0] norm_shift(input logic [63:0] x);
      logic [5:0] lp;
      lp = lead_pos64(x);
      return (lp > 6'd31) ? 6'(lp - 6'd31) : 6'd0;
   endfunction

endpackage

### rtl/bndf_if.sv
// Valid/ready channel interfaces for request and response beats.
interface bndf_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] half_x;
   logic signed [15:0] half_y;
   logic signed [15:0] half_z;
   logic [15:0]        rough_u;
   logic [15:0]        rough_v;

   modport source (output valid, half_x, half_y, half_z, rough_u, rough_v, input ready);
   modport sink (input valid, half_x, half_y, half_z, rough_u, rough_v, output ready);
endinterface

interface bndf_rsp_if import bndf_pkg::*; ();
   logic        valid;
   logic        ready;
   logic [31:0] density;
   logic [31:0] half_pdf;
   status_type  status;

   modport source (output valid, density, half_pdf, status, input ready);
   modport sink (input valid, density, half_pdf, status, output ready);
endinterface

### rtl/beckmann_ndf_evaluate.sv
// Throughput: one beat per cycle while the response is not stalled; the depth is set by
// three bit-serial divider pipelines (57, 31 and 33 stages) plus the input, denominator,
// sum, exponent, scaling and output stages.
// A stalled response holds every stage in place.
// Reset (synchronous) clears the stage valid bits only; datapath registers are not reset.
module beckmann_ndf_evaluate import bndf_pkg::*; (
   input logic         clock,
   input logic         reset,
   bndf_req_if.sink    req_bus,
   bndf_rsp_if.source  rsp_bus
);

   typedef struct packed {
      status_type  code;
      logic        pos;
      logic [15:0] az;
   } tag_type;

   typedef struct packed {
      logic [30:0] x2;
      logic [30:0] y2;
      logic [30:0] z2;
      logic [31:0] a2;
      logic [31:0] b2;
      tag_type     tag;
   } sq_type;

   typedef struct packed {
      logic [31:0] a2;
      logic [31:0] b2;
      logic [30:0] z2;
      logic [31:0] dm;
      logic [7:0]  de;
      tag_type     tag;
   } diva_type;

   typedef struct packed {
      logic        cap;
      logic [30:0] z2;
      logic [31:0] dm;
      logic [7:0]  de;
      tag_type     tag;
   } divb_type;

   typedef struct packed {
      logic [31:0] dm;
      logic [7:0]  de;
      tag_type     tag;
   } den_type;

   typedef struct packed {
      logic [31:0] dm;
      logic [7:0]  de;
      logic [7:0]  k;
      tag_type     tag;
   } divc_type;

   logic [PIPE_DEPTH-1:0] v_ff;
   logic                  adv;

   assign adv = !v_ff[PIPE_DEPTH-1] || rsp_bus.ready;
   assign req_bus.ready = adv;
   assign rsp_bus.valid = v_ff[PIPE_DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[PIPE_DEPTH-2:0], req_bus.valid};
      end
   end

   // input register
   logic [15:0] hx_ff, hy_ff, hz_ff, ru_ff, rv_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         hx_ff <= req_bus.half_x;
         hy_ff <= req_bus.half_y;
         hz_ff <= req_bus.half_z;
         ru_ff <= req_bus.rough_u;
         rv_ff <= req_bus.rough_v;
      end
   end

   // squares and special cases
   logic [15:0] ax, ay, az;
   logic [31:0] ax2, ay2, az2, a2, b2, ab;
   sq_type      sq_in, sq1_ff;
   logic [31:0] ab_ff;

   assign ax  = hx_ff[15] ? (~hx_ff + 16'd1) : hx_ff;
   assign ay  = hy_ff[15] ? (~hy_ff + 16'd1) : hy_ff;
   assign az  = hz_ff[15] ? (~hz_ff + 16'd1) : hz_ff;
   assign ax2 = ax * ax;
   assign ay2 = ay * ay;
   assign az2 = az * az;
   assign a2  = ru_ff * ru_ff;
   assign b2  = rv_ff * rv_ff;
   assign ab  = ru_ff * rv_ff;

   always_comb begin
      sq_in.x2 = ax2[30:0];
      sq_in.y2 = ay2[30:0];
      sq_in.z2 = az2[30:0];
      sq_in.a2 = a2;
      sq_in.b2 = b2;
      sq_in.tag.az = az;
      sq_in.tag.pos = !hz_ff[15] && (hz_ff != 16'd0);
      if (hz_ff == 16'd0) begin
         sq_in.tag.code = ST_GRAZE;
      end else if (ru_ff == 16'd0 || rv_ff == 16'd0) begin
         sq_in.tag.code = ST_ZERO_ROUGH;
      end else begin
         sq_in.tag.code = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq1_ff <= sq_in;
         ab_ff  <= ab;
      end
   end

   // denominator: au*av*hz^4*pi as mantissa/exponent
   logic [5:0]  ab_lead;
   logic [4:0]  ab_lz;
   logic [5:0]  sh4, sh6, sh8;
   sq_type      sq2_ff, sq3_ff, sq4_ff, sq5_ff, sq6_ff, sq7_ff, sq8_ff;
   logic [31:0] dm2_ff, dm4_ff, dm6_ff, dm8_ff;
   logic [63:0] pr3_ff, pr5_ff, pr7_ff;
   logic [7:0]  de2_ff, de3_ff, de4_ff, de5_ff, de6_ff, de7_ff, de8_ff;

   assign ab_lead = lead_pos64({32'd0, ab_ff});
   assign ab_lz   = 5'(6'd31 - ab_lead);
   assign sh4     = norm_shift(pr3_ff);
   assign sh6     = norm_shift(pr5_ff);
   assign sh8     = norm_shift(pr7_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         sq2_ff <= sq1_ff;
         dm2_ff <= ab_ff << ab_lz;
         de2_ff <= 8'd0 - 8'(ab_lz);
         sq3_ff <= sq2_ff;
         pr3_ff <= {32'd0, dm2_ff} * {33'd0, sq2_ff.z2};
         de3_ff <= de2_ff;
         sq4_ff <= sq3_ff;
         dm4_ff <= 32'(pr3_ff >> sh4);
         de4_ff <= de3_ff + {2'b00, sh4};
         sq5_ff <= sq4_ff;
         pr5_ff <= {32'd0, dm4_ff} * {33'd0, sq4_ff.z2};
         de5_ff <= de4_ff;
         sq6_ff <= sq5_ff;
         dm6_ff <= 32'(pr5_ff >> sh6);
         de6_ff <= de5_ff + {2'b00, sh6};
         sq7_ff <= sq6_ff;
         pr7_ff <= {32'd0, dm6_ff} * {32'd0, PI_Q30};
         de7_ff <= de6_ff - 8'd30;
         sq8_ff <= sq7_ff;
         dm8_ff <= 32'(pr7_ff >> sh8);
         de8_ff <= de7_ff + {2'b00, sh8};
      end
   end

   // divider A: hx^2*2^26/au^2 and hy^2*2^26/av^2, one quotient bit per stage
   logic [31:0] rx_in [DIVA_STEPS];
   logic [31:0] rx_ff [DIVA_STEPS];
   logic [31:0] ry_in [DIVA_STEPS];
   logic [31:0] ry_ff [DIVA_STEPS];
   logic [56:0] wx_in [DIVA_STEPS];
   logic [56:0] wx_ff [DIVA_STEPS];
   logic [56:0] wy_in [DIVA_STEPS];
   logic [56:0] wy_ff [DIVA_STEPS];
   diva_type    dac_in [DIVA_STEPS];
   diva_type    dac_ff [DIVA_STEPS];

   always_comb begin
      logic [31:0] prx;
      logic [31:0] pry;
      logic [56:0] pwx;
      logic [56:0] pwy;
      diva_type    pc;
      logic [32:0] tx;
      logic [32:0] ty;
      logic        gx;
      logic        gy;
      for (int j = 0; j < DIVA_STEPS; j++) begin
         if (j == 0) begin
            prx = 32'd0;
            pry = 32'd0;
            pwx = {sq8_ff.x2, 26'd0};
            pwy = {sq8_ff.y2, 26'd0};
            pc.a2 = sq8_ff.a2;
            pc.b2 = sq8_ff.b2;
            pc.z2 = sq8_ff.z2;
            pc.dm = dm8_ff;
            pc.de = de8_ff;
            pc.tag = sq8_ff.tag;
         end else begin
            prx = rx_ff[j-1];
            pry = ry_ff[j-1];
            pwx = wx_ff[j-1];
            pwy = wy_ff[j-1];
            pc = dac_ff[j-1];
         end
         tx = {prx, pwx[56]};
         ty = {pry, pwy[56]};
         gx = tx >= {1'b0, pc.a2};
         gy = ty >= {1'b0, pc.b2};
         rx_in[j] = gx ? 32'(tx - {1'b0, pc.a2}) : tx[31:0];
         ry_in[j] = gy ? 32'(ty - {1'b0, pc.b2}) : ty[31:0];
         wx_in[j] = {pwx[55:0], gx};
         wy_in[j] = {pwy[55:0], gy};
         dac_in[j] = pc;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rx_ff  <= rx_in;
         ry_ff  <= ry_in;
         wx_ff  <= wx_in;
         wy_ff  <= wy_in;
         dac_ff <= dac_in;
      end
   end

   // sum, cap test and setup of divider B
   logic [57:0] s_sum;
   diva_type    dal;
   divb_type    g_in, g_ff;
   logic [30:0] grem_ff;
   logic [30:0] gword_ff;

   assign dal   = dac_ff[DIVA_STEPS-1];
   assign s_sum = {1'b0, wx_ff[DIVA_STEPS-1]} + {1'b0, wy_ff[DIVA_STEPS-1]};

   always_comb begin
      g_in.cap = s_sum >= {22'd0, dal.z2, 5'd0};
      g_in.z2  = dal.z2;
      g_in.dm  = dal.dm;
      g_in.de  = dal.de;
      g_in.tag = dal.tag;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         g_ff     <= g_in;
         grem_ff  <= {1'b0, s_sum[34:5]};
         gword_ff <= {s_sum[4:0], 26'd0};
      end
   end

   // divider B: s*2^26/hz^2, quotient below 2^31 when not capped
   logic [30:0] rb_in [DIVB_STEPS];
   logic [30:0] rb_ff [DIVB_STEPS];
   logic [30:0] wb_in [DIVB_STEPS];
   logic [30:0] wb_ff [DIVB_STEPS];
   divb_type    dbc_in [DIVB_STEPS];
   divb_type    dbc_ff [DIVB_STEPS];

   always_comb begin
      logic [30:0] pr;
      logic [30:0] pw;
      divb_type    pc;
      logic [31:0] t;
      logic        g;
      for (int j = 0; j < DIVB_STEPS; j++) begin
         if (j == 0) begin
            pr = grem_ff;
            pw = gword_ff;
            pc = g_ff;
         end else begin
            pr = rb_ff[j-1];
            pw = wb_ff[j-1];
            pc = dbc_ff[j-1];
         end
         t = {pr, pw[30]};
         g = t >= {1'b0, pc.z2};
         rb_in[j] = g ? 31'(t - {1'b0, pc.z2}) : t[30:0];
         wb_in[j] = {pw[29:0], g};
         dbc_in[j] = pc;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rb_ff  <= rb_in;
         wb_ff  <= wb_in;
         dbc_ff <= dbc_in;
      end
   end

   // exponent to base 2, table lookup and interpolation
   divb_type              bl;
   logic [31:0]           tq;
   logic [63:0]           up;
   logic [31:0]           u_ff;
   den_type               ucar_ff, rcar_ff, icar_ff, mcar_ff;
   logic [EXP_P_W-1:0]    p;
   logic [EXP_IDX_W-1:0]  idx, idx1;
   logic [30:0]           lo_ff, hi_ff, lo_i_ff, m_ff;
   logic [23:0]           r_ff;
   logic [7:0]            k_r_ff, k_i_ff, k_m_ff;
   logic                  dir, dir_ff;
   logic [30:0]           diff, adj;
   logic [54:0]           prod, prod_ff;

   assign bl   = dbc_ff[DIVB_STEPS-1];
   assign tq   = bl.cap ? T_CAP_Q24 : {1'b0, wb_ff[DIVB_STEPS-1]};
   assign up   = {32'd0, tq} * {33'd0, LOG2E_Q30};
   assign p    = EXP_P_W'({{EXP_IDX_W{1'b0}}, u_ff[23:0]} * EXP_P_W'(EXP_TABLE_DEPTH));
   assign idx  = p[24 +: EXP_IDX_W];
   assign idx1 = idx + EXP_IDX_W'(1);
   assign dir  = lo_ff >= hi_ff;
   assign diff = dir ? (lo_ff - hi_ff) : (hi_ff - lo_ff);
   assign prod = diff * r_ff;
   assign adj  = prod_ff[54:24];

   always_ff @(posedge clock) begin
      if (adv) begin
         u_ff        <= up[61:30];
         ucar_ff.dm  <= bl.dm;
         ucar_ff.de  <= bl.de;
         ucar_ff.tag <= bl.tag;
         lo_ff       <= EXP_ROM[idx];
         hi_ff       <= EXP_ROM[idx1];
         r_ff        <= p[23:0];
         k_r_ff      <= u_ff[31:24];
         rcar_ff     <= ucar_ff;
         lo_i_ff     <= lo_ff;
         dir_ff      <= dir;
         prod_ff     <= prod;
         k_i_ff      <= k_r_ff;
         icar_ff     <= rcar_ff;
         m_ff        <= dir_ff ? (lo_i_ff - adj) : (lo_i_ff + adj);
         k_m_ff      <= k_i_ff;
         mcar_ff     <= icar_ff;
      end
   end

   // divider C: m*2^33/mantissa
   logic [31:0] rc_in [DIVC_STEPS];
   logic [31:0] rc_ff [DIVC_STEPS];
   logic [32:0] wc_in [DIVC_STEPS];
   logic [32:0] wc_ff [DIVC_STEPS];
   divc_type    dcc_in [DIVC_STEPS];
   divc_type    dcc_ff [DIVC_STEPS];

   always_comb begin
      logic [31:0] pr;
      logic [32:0] pw;
      divc_type    pc;
      logic [32:0] t;
      logic        g;
      for (int j = 0; j < DIVC_STEPS; j++) begin
         if (j == 0) begin
            pr = {1'b0, m_ff};
            pw = 33'd0;
            pc.dm = mcar_ff.dm;
            pc.de = mcar_ff.de;
            pc.k = k_m_ff;
            pc.tag = mcar_ff.tag;
         end else begin
            pr = rc_ff[j-1];
            pw = wc_ff[j-1];
            pc = dcc_ff[j-1];
         end
         t = {pr, pw[32]};
         g = t >= {1'b0, pc.dm};
         rc_in[j] = g ? 32'(t - {1'b0, pc.dm}) : t[31:0];
         wc_in[j] = {pw[31:0], g};
         dcc_in[j] = pc;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rc_ff  <= rc_in;
         wc_ff  <= wc_in;
         dcc_ff <= dcc_in;
      end
   end

   // final scaling by 2^e
   divc_type           cl;
   logic [32:0]        q;
   logic signed [9:0]  e;
   logic [9:0]         neg_e;
   logic [48:0]        val_in, val_ff;
   tag_type            etag_ff;

   assign cl    = dcc_ff[DIVC_STEPS-1];
   assign q     = wc_ff[DIVC_STEPS-1];
   assign e     = 10'sd41 - $signed({2'b00, cl.k}) - $signed({{2{cl.de[7]}}, cl.de});
   assign neg_e = 10'(-e);

   always_comb begin
      val_in = '0;
      if (!e[9]) begin
         if (e >= 10'sd48) begin
            val_in = VAL_LIMIT;
         end else if ({16'd0, q} > (VAL_LIMIT >> e[5:0])) begin
            val_in = VAL_LIMIT;
         end else begin
            val_in = {16'd0, q} << e[5:0];
         end
      end else if (neg_e < 10'd33) begin
         val_in = {16'd0, q >> neg_e[5:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         val_ff  <= val_in;
         etag_ff <= cl.tag;
      end
   end

   // output register
   logic [64:0] pdf_full;
   logic [49:0] pdf_sh;
   logic [31:0] dens_in, pdf_in, dens_ff, pdf_ff;
   status_type  st_in, st_ff;

   assign pdf_full = {16'd0, val_ff} * {49'd0, etag_ff.az};
   assign pdf_sh   = pdf_full[64:15];

   always_comb begin
      if (etag_ff.code != ST_OK) begin
         dens_in = 32'd0;
         pdf_in  = 32'd0;
         st_in   = etag_ff.code;
      end else begin
         dens_in = (val_ff > {17'd0, MASK32}) ? MASK32 : val_ff[31:0];
         if (!etag_ff.pos) begin
            pdf_in = 32'd0;
         end else begin
            pdf_in = (pdf_sh > {18'd0, MASK32}) ? MASK32 : pdf_sh[31:0];
         end
         st_in = (val_ff > {17'd0, MASK32}) ? ST_SAT : ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dens_ff <= dens_in;
         pdf_ff  <= pdf_in;
         st_ff   <= st_in;
      end
   end

   assign rsp_bus.density  = dens_ff;
   assign rsp_bus.half_pdf = pdf_ff;
   assign rsp_bus.status   = st_ff;

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.ready) |=> ($stable(v_ff) && $stable(dens_ff)
                                              && $stable(pdf_ff)))
      else $error("pipeline moved during a stalled beat");

   a_flag_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && (rsp_bus.status == ST_GRAZE || rsp_bus.status == ST_ZERO_ROUGH))
      |-> (rsp_bus.density == 32'd0 && rsp_bus.half_pdf == 32'd0))
      else $error("flagged beat carries nonzero results");

   a_pdf_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.status == ST_OK) |-> (rsp_bus.half_pdf <= rsp_bus.density))
      else $error("half_pdf exceeds density");

endmodule
